/* hw/rtl/tvtd_pkg.sv */
// ----------------------------------------------------------------------------
// tvtd_pkg
// Shared codes, character constants and small character-class helpers for
// the typed value text decoder.
// ----------------------------------------------------------------------------
package tvtd_pkg;

  localparam logic [3:0] PH_TYPE   = 4'd0;
  localparam logic [3:0] PH_SEP    = 4'd1;
  localparam logic [3:0] PH_D_HI   = 4'd2;
  localparam logic [3:0] PH_D_LO   = 4'd3;
  localparam logic [3:0] PH_D_SP   = 4'd4;
  localparam logic [3:0] PH_S_OPEN = 4'd5;
  localparam logic [3:0] PH_S_BODY = 4'd6;
  localparam logic [3:0] PH_S_ESC  = 4'd7;
  localparam logic [3:0] PH_S_OCT  = 4'd8;
  localparam logic [3:0] PH_I_WS   = 4'd9;
  localparam logic [3:0] PH_I_DIG  = 4'd10;
  localparam logic [3:0] PH_DRAIN  = 4'd11;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_UNKNOWN   = 2'd2;
  localparam logic [1:0] ST_FLOAT     = 2'd3;

  localparam logic [1:0] TYPE_DATA  = 2'd0;
  localparam logic [1:0] TYPE_STR   = 2'd1;
  localparam logic [1:0] TYPE_INT   = 2'd2;
  localparam logic [1:0] TYPE_FLOAT = 2'd3;

  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [7:0] SEP_RESET = 8'h3a;

  localparam logic [35:0] LIMIT_POS = 36'h0_7fff_ffff;
  localparam logic [35:0] LIMIT_NEG = 36'h0_8000_0000;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_of(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.nib = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.nib = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      h.nib = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      h.nib = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[8'h09:8'h0d]});
  endfunction

endpackage

/* hw/rtl/typed_value_text_decoder_unit.sv */
// ----------------------------------------------------------------------------
// typed_value_text_decoder_unit
// Decodes one typed value text (data hex pairs, C-escaped string, or decimal
// integer) one character per beat, sending bytes as they decode and a
// closing beat with the status.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  in       | in_valid, in_stall  | in_char_code, in_last
//  out      | out_valid, out_stall| data_byte, byte_valid, done_res, status,
//           |                     | value_type, int_value, saturated
//  cfg      | cfg_wr_en           | cfg_wr_data (separator character)
//
// One character is accepted every cycle while in_stall is low; it is held in
// the input register, and its result beat, if it yields one, is then
// presented from the output register. The decode state updates when a
// character leaves the input register. A stalled output register holds its
// beat while the input register keeps taking characters until one that yields
// a beat waits in it. Reset is synchronous and clears the decode state and the
// separator to a colon.
module typed_value_text_decoder_unit
  import tvtd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_data_byte,
  output logic               out_byte_valid,
  output logic               out_done_res,
  output logic [1:0]         out_status,
  output logic [1:0]         out_value_type,
  output logic signed [31:0] out_int_value,
  output logic               out_saturated,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data
);

  logic [7:0]  sep_r;

  logic        s1_valid_r;
  logic [7:0]  s1_char_r;
  logic        s1_last_r;
  logic        s1_fire;

  logic [3:0]  phase_r,   phase_nxt;
  logic [1:0]  kind_r,    kind_nxt;
  logic [3:0]  nib_r,     nib_nxt;
  logic [7:0]  oct_r,     oct_nxt;
  logic [1:0]  octcnt_r,  octcnt_nxt;
  logic [31:0] acc_r,     acc_nxt;
  logic        neg_r,     neg_nxt;
  logic        seen_r,    seen_nxt;
  logic        clamp_r,   clamp_nxt;
  logic [1:0]  err_r,     err_nxt;

  logic        have;
  logic [7:0]  byte_v;
  logic        res_vld;
  logic [31:0] iv;
  logic        sat;
  logic [35:0] acc_t;
  logic [35:0] acc_lim;
  logic [7:0]  c;
  hex_t        hx;
  logic [7:0]  oct_sh;
  logic [1:0]  octcnt_inc;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_bv_r;
  logic        out_done_r;
  logic [1:0]  out_status_r;
  logic [1:0]  out_type_r;
  logic [31:0] out_iv_r;
  logic        out_sat_r;

  function automatic logic [1:0] end_status(input logic [3:0] ph, input logic seen,
                                            input logic [1:0] err);
    logic [1:0] st;
    case (ph)
      PH_D_HI, PH_D_SP: st = ST_OK;
      PH_I_DIG:         st = seen ? ST_OK : ST_MALFORMED;
      PH_TYPE, PH_SEP, PH_D_LO, PH_S_OPEN, PH_S_BODY, PH_S_ESC, PH_S_OCT,
      PH_I_WS:          st = ST_MALFORMED;
      default:          st = err;
    endcase
    return st;
  endfunction

  assign c          = s1_char_r;
  assign hx         = hex_of(c);
  assign acc_t      = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + {32'd0, c[3:0]};
  assign acc_lim    = neg_r ? LIMIT_NEG : LIMIT_POS;
  assign oct_sh     = {oct_r[4:0], c[2:0]};
  assign octcnt_inc = octcnt_r + 2'd1;

  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    nib_nxt    = nib_r;
    oct_nxt    = oct_r;
    octcnt_nxt = octcnt_r;
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    seen_nxt   = seen_r;
    clamp_nxt  = clamp_r;
    err_nxt    = err_r;
    have       = 1'b0;
    byte_v     = 8'd0;

    if (phase_r < PH_DRAIN) begin
      if (c == CH_NUL) begin
        err_nxt   = end_status(phase_r, seen_r, err_r);
        phase_nxt = PH_DRAIN;
      end else begin
        case (phase_r)
          PH_TYPE: begin
            err_nxt   = ST_OK;
            phase_nxt = PH_SEP;
            if (c == CH_D) begin
              kind_nxt = TYPE_DATA;
            end else if (c == CH_S) begin
              kind_nxt = TYPE_STR;
            end else if (c == CH_I) begin
              kind_nxt = TYPE_INT;
            end else if (c == CH_F) begin
              kind_nxt = TYPE_FLOAT;
            end else begin
              kind_nxt = TYPE_DATA;
              err_nxt  = ST_UNKNOWN;
            end
          end
          PH_SEP: begin
            if (c != sep_r) begin
              err_nxt   = ST_MALFORMED;
              phase_nxt = PH_DRAIN;
            end else if (err_r == ST_UNKNOWN) begin
              err_nxt   = ST_UNKNOWN;
              phase_nxt = PH_DRAIN;
            end else if (kind_r == TYPE_DATA) begin
              phase_nxt = PH_D_HI;
            end else if (kind_r == TYPE_STR) begin
              phase_nxt = PH_S_OPEN;
            end else if (kind_r == TYPE_INT) begin
              phase_nxt = PH_I_WS;
            end else begin
              err_nxt   = ST_FLOAT;
              phase_nxt = PH_DRAIN;
            end
          end
          PH_D_HI: begin
            if (!hx.ok) begin
              err_nxt   = ST_MALFORMED;
              phase_nxt = PH_DRAIN;
            end else begin
              nib_nxt   = hx.nib;
              phase_nxt = PH_D_LO;
            end
          end
          PH_D_LO: begin
            if (!hx.ok) begin
              err_nxt   = ST_MALFORMED;
              phase_nxt = PH_DRAIN;
            end else begin
              byte_v    = {nib_r, hx.nib};
              have      = 1'b1;
              phase_nxt = PH_D_SP;
            end
          end
          PH_D_SP: begin
            if (c == CH_SPACE) begin
              phase_nxt = PH_D_HI;
            end else begin
              err_nxt   = ST_MALFORMED;
              phase_nxt = PH_DRAIN;
            end
          end
          PH_S_OPEN: begin
            if (c == CH_QUOTE) begin
              phase_nxt = PH_S_BODY;
            end else begin
              err_nxt   = ST_MALFORMED;
              phase_nxt = PH_DRAIN;
            end
          end
          PH_S_BODY: begin
            if (c == CH_QUOTE) begin
              err_nxt   = ST_OK;
              phase_nxt = PH_DRAIN;
            end else if (c == CH_BSLASH) begin
              phase_nxt = PH_S_ESC;
            end else begin
              byte_v = c;
              have   = 1'b1;
            end
          end
          PH_S_ESC: begin
            phase_nxt = PH_S_BODY;
            have      = 1'b1;
            case (c)
              8'h62: byte_v = 8'h08;
              8'h66: byte_v = 8'h0c;
              8'h6e: byte_v = 8'h0a;
              8'h72: byte_v = 8'h0d;
              8'h74: byte_v = 8'h09;
              8'h76: byte_v = 8'h0b;
              CH_BSLASH, CH_QUOTE: byte_v = c;
              default: begin
                have = 1'b0;
                if (c inside {[8'h30:8'h33]}) begin
                  oct_nxt    = {6'd0, c[1:0]};
                  octcnt_nxt = 2'd1;
                  phase_nxt  = PH_S_OCT;
                end else begin
                  err_nxt   = ST_MALFORMED;
                  phase_nxt = PH_DRAIN;
                end
              end
            endcase
          end
          PH_S_OCT: begin
            if (!(c inside {[8'h30:8'h37]})) begin
              err_nxt   = ST_MALFORMED;
              phase_nxt = PH_DRAIN;
            end else if (octcnt_inc == 2'd3) begin
              byte_v     = oct_sh;
              have       = 1'b1;
              oct_nxt    = oct_sh;
              octcnt_nxt = 2'd0;
              phase_nxt  = PH_S_BODY;
            end else begin
              oct_nxt    = oct_sh;
              octcnt_nxt = octcnt_inc;
            end
          end
          default: begin
            // Integer text: whitespace and sign first, then digits.
            if (phase_r == PH_I_WS && is_ws(c)) begin
              phase_nxt = PH_I_WS;
            end else if (phase_r == PH_I_WS && c == CH_PLUS) begin
              phase_nxt = PH_I_DIG;
            end else if (phase_r == PH_I_WS && c == CH_MINUS) begin
              phase_nxt = PH_I_DIG;
              neg_nxt   = 1'b1;
            end else if (c inside {[8'h30:8'h39]}) begin
              phase_nxt = PH_I_DIG;
              seen_nxt  = 1'b1;
              if (acc_t > acc_lim) begin
                acc_nxt   = acc_lim[31:0];
                clamp_nxt = 1'b1;
              end else begin
                acc_nxt = acc_t[31:0];
              end
            end else begin
              err_nxt   = (phase_r == PH_I_DIG && seen_r) ? ST_OK : ST_MALFORMED;
              phase_nxt = PH_DRAIN;
            end
          end
        endcase
      end
      if (s1_last_r && phase_nxt < PH_DRAIN) begin
        err_nxt   = end_status(phase_nxt, seen_nxt, err_nxt);
        phase_nxt = PH_DRAIN;
      end
    end

    iv  = 32'd0;
    sat = 1'b0;
    if (kind_nxt == TYPE_INT && err_nxt == ST_OK) begin
      iv  = neg_nxt ? (~acc_nxt + 32'd1) : acc_nxt;
      sat = clamp_nxt;
    end
    res_vld = have || s1_last_r;
  end

  assign s1_fire  = s1_valid_r && !(res_vld && out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= SEP_RESET;
    end else if (cfg_wr_en) begin
      sep_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_char_r <= in_char_code;
      s1_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (s1_fire && s1_last_r)) begin
      phase_r  <= PH_TYPE;
      kind_r   <= TYPE_DATA;
      nib_r    <= 4'd0;
      oct_r    <= 8'd0;
      octcnt_r <= 2'd0;
      acc_r    <= 32'd0;
      neg_r    <= 1'b0;
      seen_r   <= 1'b0;
      clamp_r  <= 1'b0;
      err_r    <= ST_OK;
    end else if (s1_fire) begin
      phase_r  <= phase_nxt;
      kind_r   <= kind_nxt;
      nib_r    <= nib_nxt;
      oct_r    <= oct_nxt;
      octcnt_r <= octcnt_nxt;
      acc_r    <= acc_nxt;
      neg_r    <= neg_nxt;
      seen_r   <= seen_nxt;
      clamp_r  <= clamp_nxt;
      err_r    <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && res_vld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_vld) begin
      out_byte_r   <= have ? byte_v : 8'd0;
      out_bv_r     <= have;
      out_done_r   <= s1_last_r;
      out_status_r <= s1_last_r ? err_nxt : ST_OK;
      out_type_r   <= kind_nxt;
      out_iv_r     <= s1_last_r ? iv : 32'd0;
      out_sat_r    <= s1_last_r ? sat : 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_byte  = out_byte_r;
  assign out_byte_valid = out_bv_r;
  assign out_done_res   = out_done_r;
  assign out_status     = out_status_r;
  assign out_value_type = out_type_r;
  assign out_int_value  = out_iv_r;
  assign out_saturated  = out_sat_r;

`ifndef SYNTH
  a_sat_only_ok_int: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_done_res && out_status == ST_OK && out_value_type == TYPE_INT))
    else $error("saturated flag on a beat that is not a closing integer");

  a_byte_beat_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_done_res) |-> (out_byte_valid && out_status == ST_OK))
    else $error("non-closing beat without a byte");

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (phase_r == PH_TYPE && err_r == ST_OK))
    else $error("decode state not cleared after the final character");

  a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && res_vld) |=> (out_valid && out_done_res == $past(s1_last_r)))
    else $error("result beat lost between stages");
`endif

endmodule
